// ===== hw/rtl/ptt_pkg.sv =====
// shared types, constants and the channel period map of the periodic trigger
`default_nettype none
package ptt_pkg;

   localparam int NUM_CHANNELS = 16;
   localparam int TICK_PERIOD  = 1;
   localparam int NUM_REGS     = 8;
   localparam int REG_W        = 16;
   localparam int REG_IDX_W    = $clog2(NUM_REGS);
   localparam int TIME_W       = 32;
   localparam int MASK_W       = 16;

   typedef logic [REG_W-1:0]     period_type;
   typedef logic [REG_IDX_W-1:0] reg_idx_type;
   typedef logic [TIME_W-1:0]    time_type;
   typedef logic [MASK_W-1:0]    mask_type;

   // transaction kinds
   localparam logic KIND_BOOT = 1'b0;
   localparam logic KIND_PASS = 1'b1;

   // register indexes
   localparam reg_idx_type REG_SENSOR      = 3'd0;
   localparam reg_idx_type REG_TEMPERATURE = 3'd1;
   localparam reg_idx_type REG_BATTERY     = 3'd2;
   localparam reg_idx_type REG_USB         = 3'd3;
   localparam reg_idx_type REG_RADIO       = 3'd4;
   localparam reg_idx_type REG_SCREEN      = 3'd5;
   localparam reg_idx_type REG_LAMP        = 3'd6;
   localparam reg_idx_type REG_CLIMATE     = 3'd7;

   localparam period_type LAMP_RESET    = 16'd100;
   localparam period_type CLIMATE_RESET = 16'd1000;

   // period source of a channel: a register or the fixed tick
   typedef struct packed {
      logic        fixed;
      reg_idx_type idx;
   } src_type;

   function automatic src_type chan_period_sel(input int ch);
      src_type s;
      s.fixed = 1'b0;
      s.idx   = REG_SENSOR;
      case (ch)
         0:       s.idx = REG_SENSOR;
         1:       s.idx = REG_TEMPERATURE;
         2:       s.idx = REG_BATTERY;
         7:       s.idx = REG_USB;
         8:       s.idx = REG_RADIO;
         11:      s.idx = REG_SENSOR;
         12:      s.idx = REG_SCREEN;
         14:      s.idx = REG_LAMP;
         15:      s.idx = REG_CLIMATE;
         default: s.fixed = 1'b1;
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ptt_if.sv =====
// valid/ready channel interfaces for the request and response sides
`default_nettype none
interface ptt_req_if;
   logic                  valid;
   logic                  ready;
   logic                  kind;
   ptt_pkg::time_type     now_ms;
   modport source (output valid, output kind, output now_ms, input ready);
   modport sink   (input valid, input kind, input now_ms, output ready);
endinterface

interface ptt_rsp_if;
   logic                  valid;
   logic                  ready;
   ptt_pkg::mask_type     fire_mask;
   modport source (output valid, output fire_mask, input ready);
   modport sink   (input valid, input fire_mask, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/periodic_task_trigger.sv =====
// top level of the sixteen-channel periodic trigger generator
// Each request transaction carries a millisecond time and a kind. The first boot
// transaction after reset stamps every channel's last-fire time; a pass compares
// each channel's wrap-safe elapsed time against its period in sixteen parallel
// subtract-compare units, restamps the channels that are due and returns their
// fire mask (zero for a boot). One response per request, registered and valid in the
// next cycle; a new request is taken every cycle while the response register is empty
// or draining. Users write period registers via the csr port only while idle; unchecked.
`default_nettype none
module periodic_task_trigger (
   input  wire                   clock,
   input  wire                   reset,
   ptt_req_if.sink               req,
   ptt_rsp_if.source             rsp,
   input  wire                   csr_we,
   input  wire ptt_pkg::reg_idx_type csr_index,
   input  wire ptt_pkg::period_type  csr_wdata
);
   import ptt_pkg::*;

   period_type period_ff [NUM_REGS];
   time_type   last_fire_ff [NUM_CHANNELS];
   time_type   last_fire_in [NUM_CHANNELS];
   logic       booted_ff, booted_in;
   logic       rsp_valid_ff, rsp_valid_in;
   mask_type   fire_mask_ff, fire_mask_in;
   logic       req_take;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign req_take  = req.valid && req.ready;

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.fire_mask = fire_mask_ff;

   always_comb begin
      src_type    s;
      period_type p;
      time_type   elapsed;
      s            = '0;
      p            = '0;
      elapsed      = '0;
      booted_in    = booted_ff;
      fire_mask_in = fire_mask_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         last_fire_in[i] = last_fire_ff[i];
      end
      if (req_take) begin
         rsp_valid_in = 1'b1;
         fire_mask_in = '0;
         if (req.kind == KIND_BOOT) begin
            // only the first boot stamps the channels
            if (!booted_ff) begin
               booted_in = 1'b1;
               for (int i = 0; i < NUM_CHANNELS; i++) begin
                  last_fire_in[i] = req.now_ms;
               end
            end
         end else begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
               s = chan_period_sel(i);
               p = s.fixed ? period_type'(TICK_PERIOD) : period_ff[s.idx];
               // modulo 2^32 difference handles counter wrap
               elapsed = req.now_ms - last_fire_ff[i];
               if (elapsed >= time_type'(p)) begin
                  last_fire_in[i] = req.now_ms;
                  fire_mask_in[i] = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         booted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            last_fire_ff[i] <= '0;
         end
         for (int r = 0; r < NUM_REGS; r++) begin
            period_ff[r] <= '0;
         end
         period_ff[REG_LAMP]    <= LAMP_RESET;
         period_ff[REG_CLIMATE] <= CLIMATE_RESET;
      end else begin
         booted_ff    <= booted_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            last_fire_ff[i] <= last_fire_in[i];
         end
         if (csr_we) begin
            period_ff[csr_index] <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      fire_mask_ff <= fire_mask_in;
   end

   a_boot_sets_flag: assert property (@(posedge clock) disable iff (reset)
      req_take && req.kind == KIND_BOOT |=> booted_ff)
      else $error("boot transaction did not set booted flag");

   a_boot_zero_mask: assert property (@(posedge clock) disable iff (reset)
      req_take && req.kind == KIND_BOOT |=> rsp_valid_ff && fire_mask_ff == '0)
      else $error("boot transaction produced a nonzero fire mask");

   a_take_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("accepted request without a response");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req.ready)
      else $error("request stalled while response register empty");

   a_boot_stamps: assert property (@(posedge clock) disable iff (reset)
      req_take && req.kind == KIND_BOOT && !booted_ff
      |=> last_fire_ff[0] == $past(req.now_ms)
          && last_fire_ff[NUM_CHANNELS-1] == $past(req.now_ms))
      else $error("first boot did not stamp channels");

endmodule
`default_nettype wire
